// ===== hw/rtl/cgrg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cgrg_pkg: shared types and constants of the ghost ring generator
// widths, fixed-point constants, sequencer states, divider request/response
// and the arctangent table used by both cordic modes
// ----------------------------------------------------------------------------
package cgrg_pkg;

  localparam int unsigned NODES    = 1024;  // power of two
  localparam int unsigned NODE_W   = $clog2(NODES);
  localparam int unsigned MAX_BINS = 16;
  localparam int unsigned BIN_W    = $clog2(MAX_BINS + 1);

  localparam int unsigned IN_TDATA_W  = 176;
  localparam int unsigned OUT_TDATA_W = 128;

  localparam int unsigned DIV_NUM_W = 64;
  localparam int unsigned DIV_DEN_W = 34;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam int unsigned CX_W = 50;  // cordic x/y
  localparam int unsigned ZW   = 40;  // cordic angle

  localparam logic [31:0] CORDIC_GAIN = 32'd2608131496;
  localparam logic [31:0] INV_TWO_PI  = 32'd683565276;

  // configuration register indexes
  localparam logic [1:0] REG_NODES_PER_H   = 2'd0;
  localparam logic [1:0] REG_KERNEL_EXTENT = 2'd1;
  localparam logic [1:0] REG_BASE_GHOST    = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SQ, S_SQRT, S_HZ, S_CACHE, S_DELTA, S_NORM, S_ATAN,
    S_THETA, S_TWOI, S_STEP, S_TM, S_TDIV, S_LIM, S_NB, S_X0, S_RINIT,
    S_ROT, S_SETTLE, S_OUTP, S_OUTN
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  localparam logic signed [CX_W:0] SAT_MAX = (CX_W+1)'(32'sh7FFF_FFFF);
  localparam logic signed [CX_W:0] SAT_MIN = (CX_W+1)'(32'sh8000_0000);

  // atan(2^-i) in turn units, 2^32 per turn
  function automatic logic [31:0] arc_angle(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h2000_0000;
      5'd1:  a = 32'h12E4_051E;
      5'd2:  a = 32'h09FB_385B;
      5'd3:  a = 32'h0511_11D4;
      5'd4:  a = 32'h028B_0D43;
      5'd5:  a = 32'h0145_D7E1;
      5'd6:  a = 32'h00A2_F61E;
      5'd7:  a = 32'h0051_7C55;
      5'd8:  a = 32'h0028_BE53;
      5'd9:  a = 32'h0014_5F2F;
      5'd10: a = 32'h000A_2F98;
      5'd11: a = 32'h0005_17CC;
      5'd12: a = 32'h0002_8BE6;
      5'd13: a = 32'h0001_45F3;
      5'd14: a = 32'h0000_A2FA;
      5'd15: a = 32'h0000_517D;
      5'd16: a = 32'h0000_28BE;
      5'd17: a = 32'h0000_145F;
      5'd18: a = 32'h0000_0A30;
      5'd19: a = 32'h0000_0518;
      5'd20: a = 32'h0000_028C;
      5'd21: a = 32'h0000_0146;
      5'd22: a = 32'h0000_00A3;
      5'd23: a = 32'h0000_0051;
      5'd24: a = 32'h0000_0029;
      5'd25: a = 32'h0000_0014;
      5'd26: a = 32'h0000_000A;
      5'd27: a = 32'h0000_0005;
      5'd28: a = 32'h0000_0003;
      5'd29: a = 32'h0000_0001;
      5'd30: a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

  // round half up by 2^16 and saturate to 32 bits
  function automatic logic [31:0] settle(input logic signed [CX_W-1:0] v);
    logic signed [CX_W:0] w;
    logic signed [CX_W:0] t;
    w = (CX_W+1)'(v) + (CX_W+1)'(32768);
    t = w >>> 16;
    if (t > SAT_MAX) t = SAT_MAX;
    if (t < SAT_MIN) t = SAT_MIN;
    return t[31:0];
  endfunction

  // magnitude of a two's complement field
  function automatic logic [31:0] field_mag(input logic [31:0] u);
    return u[31] ? (~u + 32'd1) : u;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cgrg_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cgrg_div: iterative unsigned divider
// restoring division, one quotient bit per cycle, done pulses once
// ----------------------------------------------------------------------------
module cgrg_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire cgrg_pkg::div_req_t req_i,
  output cgrg_pkg::div_rsp_t  rsp_o
);
  import cgrg_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   shifted;
  logic                 qbit;

  assign shifted = {rem_q, num_q[DIV_NUM_W-1]};
  assign qbit    = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? DIV_DEN_W'(shifted - {1'b0, den_q}) : shifted[DIV_DEN_W-1:0];
      num_d = {num_q[DIV_NUM_W-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule
`default_nettype wire

// ===== hw/rtl/cylindrical_ghost_ring_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cylindrical_ghost_ring_generator: mirrored ghost pairs on an azimuthal ring
// one plane node in, up to 2*MAX_BINS ghost beats out, with a per-node cache
// of the azimuthal step
// ----------------------------------------------------------------------------
//
// channel   dir  width  contents
// s_axis    in   176    node, radius, axial, h_xz, h_yz, h_zz; tuser first_of_pass
// m_axis    out  128    ghost index, control index, x, y, z; tlast, tuser clipped
// cfg       in   16     nodes_per_h, kernel_extent, base_ghost_index
//
// timing: a node's time is set by the iterative divider and the 32-step cordic;
//   its first visit adds the step computation and the normalising shifts, which a
//   cached step skips, and each bin adds a cordic rotation and the output waits
// reset: the step cache is swept to zero, one entry a cycle, over all NODES
//   entries after reset; the input is not ready meanwhile, config writes are taken
// stalls: each ghost beat is held until taken; the input stays not ready
//   until the last beat of the node has gone
//
module cylindrical_ghost_ring_generator (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration
  input  wire                               cfg_we_i,
  input  wire  [1:0]                        cfg_idx_i,
  input  wire  [15:0]                       cfg_data_i,
  // node input
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // node_index, radius, axial, h_xz, h_yz, h_zz (lowest bit up)
  input  wire  [cgrg_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // first_of_pass
  input  wire                               s_axis_tuser_i,
  // ghost output
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  // ghost_index, control_index, ghost_z, ghost_x, ghost_y (lowest bit up)
  output logic [cgrg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  // bins_clipped
  output logic                              m_axis_tuser_o
);
  import cgrg_pkg::*;

  localparam logic [DIV_NUM_W-1:0] ONE_TURN  = DIV_NUM_W'(64'h1_0000_0000);
  localparam logic [DIV_NUM_W-1:0] HALF_TURN = DIV_NUM_W'(64'h8000_0000);
  localparam logic [36:0]          QUARTER   = 37'h0_4000_0000;

  state_e state_q, state_d;

  // configuration
  logic [15:0] nph_q, ke_q, base_q;

  // node registers
  logic [9:0]  node_q;
  logic [30:0] r_q;
  logic [31:0] axial_q, hxz_q, hyz_q, hzz_q;

  // sequencer counters
  logic [1:0]  cnt_q, cnt_d;
  logic [4:0]  it_q, it_d;
  logic        dl_q, dl_d;        // divide launched in this state
  logic [NODE_W-1:0] clr_q, clr_d;

  // working registers
  logic [63:0] acc_q, acc_d;
  logic [63:0] res_q, res_d;
  logic [63:0] prod_q;
  logic [31:0] hz_q, hz_d;
  logic [31:0] step_q, step_d;
  logic [30:0] theta_q, theta_d;
  logic [32:0] twoi_q, twoi_d;
  logic [33:0] t_q, t_d;
  logic [47:0] x0_q, x0_d;
  logic [36:0] phi_q, phi_d;
  logic [BIN_W-1:0] nb_q, nb_d, kb_q, kb_d;
  logic        clip_q, clip_d;
  logic signed [CX_W-1:0] xc_q, xc_d, yc_q, yc_d;
  logic signed [ZW-1:0]   zc_q, zc_d;
  logic [31:0] c_q, c_d, sp_q, sp_d, sn_q, sn_d;
  logic [15:0] gcnt_q, gcnt_d;

  // step cache
  logic [31:0] cache_mem [NODES];
  logic [31:0] rd_q;
  logic        mem_we;
  logic [NODE_W-1:0] mem_waddr, slot;
  logic [31:0] mem_wdata;

  // shared units
  logic [31:0] mul_a, mul_b;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic in_acc, out_acc, div_done;
  logic [63:0] quot;

  // combinational helpers
  logic [5:0]  sq_sh;
  logic [63:0] sq_bit, sq_t, sq_res_nx;
  logic        sq_ge;
  logic signed [CX_W-1:0] sh_x, sh_y;
  logic signed [ZW-1:0]   arc;
  logic        up;
  logic [31:0] cap;
  logic [63:0] lim_sh;
  logic [32:0] tw_raw;
  logic        small_xy;

  cgrg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = m_axis_tvalid_o && m_axis_tready_i;
  assign div_done = drsp.done;
  assign quot     = drsp.quot;
  assign slot     = node_q[NODE_W-1:0];  // node index modulo a power-of-two store

  // square root step, one result bit a cycle
  assign sq_sh     = 6'd62 - {it_q, 1'b0};
  assign sq_bit    = 64'd1 << sq_sh;
  assign sq_t      = res_q + sq_bit;
  assign sq_ge     = acc_q >= sq_t;
  assign sq_res_nx = sq_ge ? ((res_q >> 1) + sq_bit) : (res_q >> 1);

  // cordic step shared by vectoring (atan2) and rotation (sin/cos)
  assign sh_x = xc_q >>> it_q;
  assign sh_y = yc_q >>> it_q;
  assign arc  = $signed(ZW'(arc_angle(it_q)));
  assign up   = (state_q == S_ATAN) ? !yc_q[CX_W-1] : zc_q[ZW-1];

  assign cap      = 32'h8000_0000 - step_q;
  assign lim_sh   = acc_q >> 9;
  assign tw_raw   = (quot < 64'd2) ? 33'd2 : quot[32:0];
  assign small_xy = (xc_q[CX_W-1:40] == '0) && (yc_q[CX_W-1:40] == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == NODE_W'(NODES - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = S_SQ;
      S_SQ:    if (cnt_q == 2'd3) state_d = S_SQRT;
      S_SQRT: begin
        if (it_q == 5'd31) state_d = (sq_res_nx == '0) ? S_CACHE : S_HZ;
      end
      S_HZ:    if (div_done) state_d = S_CACHE;
      S_CACHE: state_d = (rd_q != '0) ? S_TM : S_DELTA;
      S_DELTA: begin
        if (div_done) state_d = (r_q == '0 && quot == '0) ? S_TWOI : S_NORM;
      end
      S_NORM:  if (!small_xy) state_d = S_ATAN;
      S_ATAN:  if (it_q == 5'd31) state_d = S_THETA;
      S_THETA: state_d = S_TWOI;
      S_TWOI:  if (theta_q == '0 || div_done) state_d = S_STEP;
      S_STEP:  if (div_done) state_d = S_TM;
      S_TM:    if (cnt_q == 2'd1) state_d = (r_q == '0) ? S_NB : S_TDIV;
      S_TDIV: begin
        if (div_done) state_d = (quot[63:34] != '0) ? S_NB : S_LIM;
      end
      S_LIM:   if (cnt_q == 2'd3) state_d = S_NB;
      S_NB:    if (div_done) state_d = S_X0;
      S_X0:    if (cnt_q == 2'd1) state_d = S_RINIT;
      S_RINIT: state_d = S_ROT;
      S_ROT:   if (it_q == 5'd31) state_d = S_SETTLE;
      S_SETTLE: state_d = S_OUTP;
      S_OUTP:  if (out_acc) state_d = S_OUTN;
      S_OUTN:  if (out_acc) state_d = (kb_q == nb_q) ? S_IDLE : S_RINIT;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and shared unit controls
  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    m_axis_tvalid_o = (state_q == S_OUTP) || (state_q == S_OUTN);
    m_axis_tlast_o  = (state_q == S_OUTN) && (kb_q == nb_q);
    m_axis_tuser_o  = clip_q;
    m_axis_tdata_o  = {6'd0, (state_q == S_OUTN) ? sn_q : sp_q, c_q, axial_q, node_q,
                       gcnt_q};

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ: begin
        case (cnt_q)
          2'd0:    mul_a = field_mag(hxz_q);
          2'd1:    mul_a = field_mag(hyz_q);
          2'd2:    mul_a = field_mag(hzz_q);
          default: mul_a = '0;
        endcase
        mul_b = mul_a;
      end
      S_TM: begin
        mul_a = hz_q;
        mul_b = 32'({ke_q, 1'b0}) + 32'(ke_q);
      end
      S_LIM: begin
        mul_a = (cnt_q == 2'd0) ? t_q[31:0] : {30'd0, t_q[33:32]};
        mul_b = INV_TWO_PI;
      end
      S_X0: begin
        mul_a = {1'b0, r_q};
        mul_b = CORDIC_GAIN;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    case (state_q)
      S_HZ: begin
        dreq.num = ONE_TURN;
        dreq.den = DIV_DEN_W'(res_q[31:0]);
      end
      S_DELTA: begin
        dreq.num = DIV_NUM_W'({hz_q, 8'd0});
        dreq.den = (nph_q == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(nph_q);
      end
      S_TWOI: begin
        dreq.num = HALF_TURN;
        dreq.den = DIV_DEN_W'(theta_q);
      end
      S_STEP: begin
        dreq.num = ONE_TURN;
        dreq.den = DIV_DEN_W'(twoi_q) + DIV_DEN_W'(1);
      end
      S_TDIV: begin
        dreq.num = acc_q;
        dreq.den = DIV_DEN_W'(r_q);
      end
      S_NB: begin
        dreq.num = (acc_q << 1) + DIV_NUM_W'(step_q);
        dreq.den = DIV_DEN_W'({step_q, 1'b0});
      end
      default: begin
        dreq.num = '0;
        dreq.den = '0;
      end
    endcase
    dreq.start = !dl_q &&
                 ((state_q == S_HZ) || (state_q == S_DELTA) || (state_q == S_STEP) ||
                  (state_q == S_TDIV) || (state_q == S_NB) ||
                  ((state_q == S_TWOI) && (theta_q != '0)));

    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = '0;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (state_q == S_STEP && div_done) begin
      mem_we    = 1'b1;
      mem_wdata = step_d;
    end
  end

  // datapath
  always_comb begin
    cnt_d   = (state_d != state_q) ? 2'd0 : cnt_q + 2'd1;
    it_d    = (state_d != state_q) ? 5'd0 : it_q + 5'd1;
    dl_d    = (state_d != state_q) ? 1'b0 : (dl_q | dreq.start);
    clr_d   = (state_q == S_CLEAR) ? clr_q + 1'b1 : clr_q;
    acc_d   = acc_q;
    res_d   = res_q;
    hz_d    = hz_q;
    step_d  = step_q;
    theta_d = theta_q;
    twoi_d  = twoi_q;
    t_d     = t_q;
    x0_d    = x0_q;
    phi_d   = phi_q;
    nb_d    = nb_q;
    kb_d    = kb_q;
    clip_d  = clip_q;
    xc_d    = xc_q;
    yc_d    = yc_q;
    zc_d    = zc_q;
    c_d     = c_q;
    sp_d    = sp_q;
    sn_d    = sn_q;
    gcnt_d  = gcnt_q;

    case (state_q)
      S_IDLE: begin
        acc_d = '0;
        if (in_acc && s_axis_tuser_i) gcnt_d = base_q;
      end
      S_SQ: begin
        if (cnt_q != 2'd0) acc_d = acc_q + prod_q;
        res_d = '0;
      end
      S_SQRT: begin
        if (sq_ge) acc_d = acc_q - sq_t;
        res_d = sq_res_nx;
        if (it_q == 5'd31 && sq_res_nx == '0) hz_d = '1;
      end
      S_HZ: begin
        if (div_done) hz_d = (quot[63:32] != '0) ? 32'hFFFF_FFFF : quot[31:0];
      end
      S_CACHE: begin
        if (rd_q != '0) step_d = rd_q;
      end
      S_DELTA: begin
        if (div_done) begin
          xc_d    = $signed(CX_W'({r_q, 1'b0}));
          yc_d    = $signed(CX_W'(quot[39:0]));
          theta_d = '0;
        end
      end
      S_NORM: begin
        if (small_xy) begin
          xc_d = xc_q <<< 1;
          yc_d = yc_q <<< 1;
        end
        zc_d = '0;
      end
      S_ATAN, S_ROT: begin
        if (up) begin
          xc_d = xc_q + sh_y;
          yc_d = yc_q - sh_x;
          zc_d = zc_q + arc;
        end else begin
          xc_d = xc_q - sh_y;
          yc_d = yc_q + sh_x;
          zc_d = zc_q - arc;
        end
      end
      S_THETA: begin
        if (zc_q[ZW-1]) theta_d = '0;
        else if (zc_q > $signed(ZW'(QUARTER))) theta_d = 31'h4000_0000;
        else theta_d = zc_q[30:0];
      end
      S_TWOI: begin
        if (theta_q == '0) twoi_d = 33'h1_0000_0000;
        else if (div_done) twoi_d = tw_raw + 33'(tw_raw[0]);
      end
      S_STEP: begin
        if (div_done) step_d = (quot == '0) ? 32'd1 : quot[31:0];
      end
      S_TM: begin
        if (cnt_q == 2'd1) acc_d = (r_q == '0) ? 64'(cap) : prod_q;
      end
      S_TDIV: begin
        if (div_done) begin
          if (quot[63:34] != '0) acc_d = 64'(cap);
          t_d = quot[33:0];
        end
      end
      S_LIM: begin
        case (cnt_q)
          2'd1:    acc_d = prod_q;
          2'd2:    acc_d = acc_q + {prod_q[31:0], 32'd0};
          2'd3:    acc_d = (lim_sh > 64'(cap)) ? 64'(cap) : lim_sh;
          default: acc_d = acc_q;
        endcase
      end
      S_NB: begin
        if (div_done) begin
          clip_d = quot > 64'(MAX_BINS);
          if (quot == '0) nb_d = BIN_W'(1);
          else if (quot > 64'(MAX_BINS)) nb_d = BIN_W'(MAX_BINS);
          else nb_d = quot[BIN_W-1:0];
        end
      end
      S_X0: begin
        if (cnt_q == 2'd1) begin
          x0_d  = prod_q[63:16];
          phi_d = 37'(step_q);
          kb_d  = BIN_W'(1);
        end
      end
      S_RINIT: begin
        // past a quarter turn: start from the quarter-turn rotated vector
        if (phi_q >= QUARTER) begin
          xc_d = '0;
          yc_d = $signed(CX_W'(x0_q));
          zc_d = $signed({3'd0, phi_q - QUARTER});
        end else begin
          xc_d = $signed(CX_W'(x0_q));
          yc_d = '0;
          zc_d = $signed({3'd0, phi_q});
        end
      end
      S_SETTLE: begin
        c_d  = settle(xc_q);
        sp_d = settle(yc_q);
        sn_d = settle(-yc_q);
      end
      S_OUTN: begin
        if (out_acc) begin
          kb_d  = kb_q + 1'b1;
          phi_d = phi_q + 37'(step_q);
        end
      end
      default: begin
        acc_d = acc_q;
      end
    endcase

    if (out_acc) gcnt_d = gcnt_q + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      it_q    <= '0;
      dl_q    <= 1'b0;
      clr_q   <= '0;
      gcnt_q  <= '0;
      nph_q   <= 16'd512;
      ke_q    <= 16'd512;
      base_q  <= 16'd1024;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      it_q    <= it_d;
      dl_q    <= dl_d;
      clr_q   <= clr_d;
      gcnt_q  <= gcnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NODES_PER_H:   nph_q  <= cfg_data_i;
          REG_KERNEL_EXTENT: ke_q   <= cfg_data_i;
          REG_BASE_GHOST:    base_q <= cfg_data_i;
          default:           base_q <= base_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      node_q  <= s_axis_tdata_i[9:0];
      r_q     <= s_axis_tdata_i[40:10];
      axial_q <= s_axis_tdata_i[72:41];
      hxz_q   <= s_axis_tdata_i[104:73];
      hyz_q   <= s_axis_tdata_i[136:105];
      hzz_q   <= s_axis_tdata_i[168:137];
    end
    prod_q  <= mul_a * mul_b;
    acc_q   <= acc_d;
    res_q   <= res_d;
    hz_q    <= hz_d;
    step_q  <= step_d;
    theta_q <= theta_d;
    twoi_q  <= twoi_d;
    t_q     <= t_d;
    x0_q    <= x0_d;
    phi_q   <= phi_d;
    nb_q    <= nb_d;
    kb_q    <= kb_d;
    clip_q  <= clip_d;
    xc_q    <= xc_d;
    yc_q    <= yc_d;
    zc_q    <= zc_d;
    c_q     <= c_d;
    sp_q    <= sp_d;
    sn_q    <= sn_d;
  end

  // step cache, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) cache_mem[mem_waddr] <= mem_wdata;
    rd_q <= cache_mem[slot];
  end

endmodule
`default_nettype wire
